// ===== src/clipped_cosine_similarity_unit_macros.svh =====
// Assertion macros shared by the clipped cosine similarity unit.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef CLIPPED_COSINE_SIMILARITY_UNIT_MACROS_SVH
`define CLIPPED_COSINE_SIMILARITY_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ccs_pkg.sv =====
`timescale 1ns / 1ps

package ccs_pkg;

	localparam int FIELD_W  = 16;
	localparam int SIM_W    = 17;
	localparam int ACC_W    = 48;
	localparam int HALF_W   = 24;
	localparam int PROD_W   = 48;
	localparam int WIDE_W   = 96;
	localparam int NUM_W    = 128;
	localparam int ROOT_W   = 130;
	localparam int STEP_W   = 5;
	localparam int WCNT_W   = 3;

	localparam logic [SIM_W-1:0]  ONE_Q16    = 17'h10000;
	localparam logic [ACC_W-1:0]  ACC_MAX    = {ACC_W{1'b1}};
	localparam logic [STEP_W-1:0] ROOT_STEPS = 5'd17;
	localparam logic [FIELD_W-1:0] CLIP_RESET = 16'hFFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_AA,
		ST_SQ_BB,
		ST_SQ_AB,
		ST_ACC_AB,
		ST_WIDE,
		ST_DRAIN,
		ST_ROOT_GO,
		ST_ROOT_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		DST_NONE,
		DST_AA,
		DST_BB,
		DST_AB,
		DST_DEN,
		DST_NUM
	} dest_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_24,
		SH_48
	} shift_t;

	typedef struct packed {
		dest_t  dest;
		shift_t shift;
	} mul_tag_t;

	typedef struct packed {
		logic             done;
		logic [SIM_W-1:0] q;
	} root_stat_t;

endpackage

// ===== src/ccs_chan_if.sv =====
`timescale 1ns / 1ps

interface ccs_in_if;
	logic                         valid;
	logic                         ready;
	logic [ccs_pkg::FIELD_W-1:0]  count_a;
	logic [ccs_pkg::FIELD_W-1:0]  count_b;
	logic                         last_element;

	modport source (output valid, count_a, count_b, last_element, input ready);
	modport sink (input valid, count_a, count_b, last_element, output ready);
endinterface

interface ccs_out_if;
	logic                        valid;
	logic                        ready;
	logic [ccs_pkg::SIM_W-1:0]   similarity;
	logic                        zero_norm;
	logic                        saturated;

	modport source (output valid, similarity, zero_norm, saturated, input ready);
	modport sink (input valid, similarity, zero_norm, saturated, output ready);
endinterface

interface ccs_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ccs_pkg::FIELD_W-1:0]  clip_limit;

	modport source (output valid, clip_limit, input ready);
	modport sink (input valid, clip_limit, output ready);
endinterface

// ===== src/ccs_mul.sv =====
`timescale 1ns / 1ps

module ccs_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [ccs_pkg::HALF_W-1:0]     x,
	input  logic [ccs_pkg::HALF_W-1:0]     y,
	input  ccs_pkg::mul_tag_t              tag,
	output logic [ccs_pkg::PROD_W-1:0]     prod_q,
	output ccs_pkg::mul_tag_t              tag_q
);

	always_ff @(posedge clk) begin
		prod_q <= x * y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '{dest: ccs_pkg::DST_NONE, shift: ccs_pkg::SH_0};
		end else begin
			tag_q <= tag;
		end
	end

endmodule

// ===== src/ccs_root.sv =====
`timescale 1ns / 1ps

module ccs_root (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ccs_pkg::WIDE_W-1:0]    den,
	input  logic [ccs_pkg::WIDE_W-1:0]    num,
	output ccs_pkg::root_stat_t           stat
);

	logic [ccs_pkg::ROOT_W-1:0] s_q;
	logic [ccs_pkg::ROOT_W-1:0] f_q;
	logic [ccs_pkg::ROOT_W-1:0] e_q;
	logic [ccs_pkg::NUM_W-1:0]  n_q;
	logic [ccs_pkg::SIM_W-1:0]  q_q;
	logic [ccs_pkg::STEP_W-1:0] step_q;
	logic                       busy_q;
	logic                       done_q;
	logic [ccs_pkg::ROOT_W-1:0] cand;
	logic                       take;

	// The result bit q is built from the top down. s_q holds q*q*den, f_q holds
	// 2*q*den shifted to the current bit and e_q holds den shifted to twice the
	// current bit, so each trial needs only an add and a compare.
	assign cand = s_q + f_q + e_q;
	assign take = cand <= {2'b00, n_q};

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= '0;
			f_q <= '0;
			e_q <= {2'b00, den, 32'h0};
			n_q <= {num, 32'h0};
			q_q <= '0;
		end else if (busy_q) begin
			if (take) begin
				s_q <= cand;
				f_q <= (f_q >> 1) + e_q;
			end else begin
				f_q <= f_q >> 1;
			end
			e_q <= e_q >> 2;
			q_q <= {q_q[ccs_pkg::SIM_W-2:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= ccs_pkg::ROOT_STEPS;
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.done = done_q;
	assign stat.q    = q_q[ccs_pkg::SIM_W-1] ? ccs_pkg::ONE_Q16 : q_q;

endmodule

// ===== src/clipped_cosine_similarity_unit.sv =====
`timescale 1ns / 1ps
// Clipped cosine similarity unit. Each transfer on samples carries one pair of
// counts; a count above clip_limit counts as zero. The three sums of products
// go through one shared 24x24 multiplier, so a pair that is not marked last
// holds samples not ready through ST_SQ_AA, ST_SQ_BB, ST_SQ_AB and ST_ACC_AB
// before the next pair can be taken. On the pair marked last, the two 96-bit
// products sum_aa*sum_bb and sum_ab^2 take eight more passes through the same
// multiplier, and a shift-and-add root search settles one result bit per cycle
// until every bit of the result is known; when a norm is zero both are skipped
// and the result is zero with zero_norm set. The result is held until it is taken;
// samples is not ready meanwhile, and the sums and the saturation flag clear with
// the result transfer. clip_limit may be written at any time the block is idle.

`include "clipped_cosine_similarity_unit_macros.svh"

module clipped_cosine_similarity_unit #(
	parameter int COUNT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ccs_in_if.sink     samples,
	ccs_out_if.source  result,
	ccs_cfg_if.sink    cfg
);

	ccs_pkg::state_t state_q;
	ccs_pkg::state_t state_d;

	logic [ccs_pkg::FIELD_W-1:0] clip_q;
	logic [COUNT_BITS-1:0]       a_q;
	logic [COUNT_BITS-1:0]       b_q;
	logic                        last_q;
	logic [ccs_pkg::ACC_W-1:0]   aa_q;
	logic [ccs_pkg::ACC_W-1:0]   bb_q;
	logic [ccs_pkg::ACC_W-1:0]   ab_q;
	logic                        sat_q;
	logic [ccs_pkg::WIDE_W-1:0]  den_q;
	logic [ccs_pkg::WIDE_W-1:0]  num_q;
	logic [ccs_pkg::SIM_W-1:0]   sim_q;
	logic                        zero_q;
	logic [ccs_pkg::WCNT_W-1:0]  cnt_q;

	logic [COUNT_BITS-1:0]       lim;
	logic [COUNT_BITS-1:0]       a_m;
	logic [COUNT_BITS-1:0]       b_m;
	logic [ccs_pkg::HALF_W-1:0]  mul_x;
	logic [ccs_pkg::HALF_W-1:0]  mul_y;
	ccs_pkg::mul_tag_t           mul_tag;
	logic [ccs_pkg::PROD_W-1:0]  prod;
	ccs_pkg::mul_tag_t           prod_tag;
	logic                        root_start;
	ccs_pkg::root_stat_t         root_stat;
	logic                        in_xfer;
	logic                        out_xfer;
	logic                        zero_now;

	logic [ccs_pkg::ACC_W-1:0]   acc_sel;
	logic [ccs_pkg::ACC_W:0]     acc_sum;
	logic                        acc_ovf;
	logic [ccs_pkg::ACC_W-1:0]   acc_new;
	logic [ccs_pkg::WIDE_W-1:0]  placed;
	logic [ccs_pkg::WIDE_W-1:0]  wide_sum;

	assign in_xfer  = samples.valid && samples.ready;
	assign out_xfer = result.valid && result.ready;
	assign zero_now = (aa_q == '0) || (bb_q == '0);

	assign lim = clip_q[COUNT_BITS-1:0];
	assign a_m = (samples.count_a[COUNT_BITS-1:0] > lim) ? '0 : samples.count_a[COUNT_BITS-1:0];
	assign b_m = (samples.count_b[COUNT_BITS-1:0] > lim) ? '0 : samples.count_b[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= ccs_pkg::CLIP_RESET;
		end else if (cfg.valid && cfg.ready) begin
			clip_q <= cfg.clip_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccs_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ccs_pkg::ST_WIDE) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		mul_x      = '0;
		mul_y      = '0;
		mul_tag    = '{dest: ccs_pkg::DST_NONE, shift: ccs_pkg::SH_0};
		root_start = 1'b0;
		unique case (state_q)
			ccs_pkg::ST_IDLE: begin
				if (samples.valid) begin
					state_d = ccs_pkg::ST_SQ_AA;
				end
			end
			ccs_pkg::ST_SQ_AA: begin
				mul_x   = ccs_pkg::HALF_W'(a_q);
				mul_y   = ccs_pkg::HALF_W'(a_q);
				mul_tag = '{dest: ccs_pkg::DST_AA, shift: ccs_pkg::SH_0};
				state_d = ccs_pkg::ST_SQ_BB;
			end
			ccs_pkg::ST_SQ_BB: begin
				mul_x   = ccs_pkg::HALF_W'(b_q);
				mul_y   = ccs_pkg::HALF_W'(b_q);
				mul_tag = '{dest: ccs_pkg::DST_BB, shift: ccs_pkg::SH_0};
				state_d = ccs_pkg::ST_SQ_AB;
			end
			ccs_pkg::ST_SQ_AB: begin
				mul_x   = ccs_pkg::HALF_W'(a_q);
				mul_y   = ccs_pkg::HALF_W'(b_q);
				mul_tag = '{dest: ccs_pkg::DST_AB, shift: ccs_pkg::SH_0};
				state_d = ccs_pkg::ST_ACC_AB;
			end
			ccs_pkg::ST_ACC_AB: begin
				if (!last_q) begin
					state_d = ccs_pkg::ST_IDLE;
				end else if (zero_now) begin
					state_d = ccs_pkg::ST_OUT;
				end else begin
					state_d = ccs_pkg::ST_WIDE;
				end
			end
			ccs_pkg::ST_WIDE: begin
				unique case (cnt_q)
					3'd0: begin
						mul_x   = aa_q[23:0];
						mul_y   = bb_q[23:0];
						mul_tag = '{dest: ccs_pkg::DST_DEN, shift: ccs_pkg::SH_0};
					end
					3'd1: begin
						mul_x   = aa_q[23:0];
						mul_y   = bb_q[47:24];
						mul_tag = '{dest: ccs_pkg::DST_DEN, shift: ccs_pkg::SH_24};
					end
					3'd2: begin
						mul_x   = aa_q[47:24];
						mul_y   = bb_q[23:0];
						mul_tag = '{dest: ccs_pkg::DST_DEN, shift: ccs_pkg::SH_24};
					end
					3'd3: begin
						mul_x   = aa_q[47:24];
						mul_y   = bb_q[47:24];
						mul_tag = '{dest: ccs_pkg::DST_DEN, shift: ccs_pkg::SH_48};
					end
					3'd4: begin
						mul_x   = ab_q[23:0];
						mul_y   = ab_q[23:0];
						mul_tag = '{dest: ccs_pkg::DST_NUM, shift: ccs_pkg::SH_0};
					end
					3'd5: begin
						mul_x   = ab_q[23:0];
						mul_y   = ab_q[47:24];
						mul_tag = '{dest: ccs_pkg::DST_NUM, shift: ccs_pkg::SH_24};
					end
					3'd6: begin
						mul_x   = ab_q[47:24];
						mul_y   = ab_q[23:0];
						mul_tag = '{dest: ccs_pkg::DST_NUM, shift: ccs_pkg::SH_24};
					end
					3'd7: begin
						mul_x   = ab_q[47:24];
						mul_y   = ab_q[47:24];
						mul_tag = '{dest: ccs_pkg::DST_NUM, shift: ccs_pkg::SH_48};
						state_d = ccs_pkg::ST_DRAIN;
					end
				endcase
			end
			ccs_pkg::ST_DRAIN: begin
				state_d = ccs_pkg::ST_ROOT_GO;
			end
			ccs_pkg::ST_ROOT_GO: begin
				root_start = 1'b1;
				state_d    = ccs_pkg::ST_ROOT_WAIT;
			end
			ccs_pkg::ST_ROOT_WAIT: begin
				if (root_stat.done) begin
					state_d = ccs_pkg::ST_OUT;
				end
			end
			ccs_pkg::ST_OUT: begin
				if (result.ready) begin
					state_d = ccs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ccs_pkg::ST_IDLE;
			end
		endcase
	end

	ccs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.x      (mul_x),
		.y      (mul_y),
		.tag    (mul_tag),
		.prod_q (prod),
		.tag_q  (prod_tag)
	);

	ccs_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.den    (den_q),
		.num    (num_q),
		.stat   (root_stat)
	);

	always_comb begin
		case (prod_tag.dest)
			ccs_pkg::DST_BB: acc_sel = bb_q;
			ccs_pkg::DST_AB: acc_sel = ab_q;
			default:         acc_sel = aa_q;
		endcase
	end

	assign acc_sum = {1'b0, acc_sel} + {1'b0, prod};
	assign acc_ovf = acc_sum[ccs_pkg::ACC_W];
	assign acc_new = acc_ovf ? ccs_pkg::ACC_MAX : acc_sum[ccs_pkg::ACC_W-1:0];

	always_comb begin
		case (prod_tag.shift)
			ccs_pkg::SH_24: placed = {24'h0, prod, 24'h0};
			ccs_pkg::SH_48: placed = {prod, 48'h0};
			default:        placed = {48'h0, prod};
		endcase
	end

	assign wide_sum = ((prod_tag.dest == ccs_pkg::DST_NUM) ? num_q : den_q) + placed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aa_q  <= '0;
			bb_q  <= '0;
			ab_q  <= '0;
			sat_q <= 1'b0;
		end else if (out_xfer) begin
			aa_q  <= '0;
			bb_q  <= '0;
			ab_q  <= '0;
			sat_q <= 1'b0;
		end else begin
			unique case (prod_tag.dest)
				ccs_pkg::DST_AA: begin
					aa_q  <= acc_new;
					sat_q <= sat_q | acc_ovf;
				end
				ccs_pkg::DST_BB: begin
					bb_q  <= acc_new;
					sat_q <= sat_q | acc_ovf;
				end
				ccs_pkg::DST_AB: begin
					ab_q  <= acc_new;
					sat_q <= sat_q | acc_ovf;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			a_q    <= a_m;
			b_q    <= b_m;
			last_q <= samples.last_element;
		end
		if (state_q == ccs_pkg::ST_ACC_AB) begin
			den_q <= '0;
			num_q <= '0;
		end else if (prod_tag.dest == ccs_pkg::DST_DEN) begin
			den_q <= wide_sum;
		end else if (prod_tag.dest == ccs_pkg::DST_NUM) begin
			num_q <= wide_sum;
		end
		if (state_q == ccs_pkg::ST_ACC_AB && last_q && zero_now) begin
			sim_q  <= '0;
			zero_q <= 1'b1;
		end else if (root_stat.done) begin
			sim_q  <= root_stat.q;
			zero_q <= 1'b0;
		end
	end

	assign samples.ready     = state_q == ccs_pkg::ST_IDLE;
	assign cfg.ready         = 1'b1;
	assign result.valid      = state_q == ccs_pkg::ST_OUT;
	assign result.similarity = sim_q;
	assign result.zero_norm  = zero_q;
	assign result.saturated  = sat_q;

	`CCS_ASSERT_IMPL(a_out_blocks_in, result.valid, !samples.ready, "input ready while a result is held")
	`CCS_ASSERT_IMPL(a_zero_sim, result.valid && result.zero_norm, result.similarity == '0, "zero norm with nonzero similarity")
	`CCS_ASSERT_IMPL(a_sim_range, result.valid, result.similarity <= ccs_pkg::ONE_Q16, "similarity above one")
	`CCS_ASSERT_NEXT(a_clear_after_out, out_xfer, aa_q == '0 && bb_q == '0 && ab_q == '0 && !sat_q, "sums not cleared after result transfer")
	`CCS_ASSERT_IMPL(a_root_done_state, root_stat.done, state_q == ccs_pkg::ST_ROOT_WAIT, "root finished outside its wait state")

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 3_000_000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic [ccs_pkg::FIELD_W-1:0] count_a;
		logic [ccs_pkg::FIELD_W-1:0] count_b;
		logic                        last_element;
	} pair_t;

	typedef struct {
		logic [ccs_pkg::SIM_W-1:0] similarity;
		logic                      zero_norm;
		logic                      saturated;
	} similarity_t;

	logic clk = 1'b0;
	logic arst_n;

	ccs_in_if  samples_if ();
	ccs_out_if result_if ();
	ccs_cfg_if cfg_if ();

	clipped_cosine_similarity_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.result  (result_if),
		.cfg     (cfg_if)
	);

	always #5 clk = ~clk;

	pair_t                       pairs_pending[$];
	similarity_t                 similarity_due[$];
	pair_t                       drive_pair;
	logic [ccs_pkg::FIELD_W-1:0] clip_setting = ccs_pkg::CLIP_RESET;
	logic [ccs_pkg::ACC_W-1:0]   sum_aa = '0;
	logic [ccs_pkg::ACC_W-1:0]   sum_bb = '0;
	logic [ccs_pkg::ACC_W-1:0]   sum_ab = '0;
	logic                        overflow_seen = 1'b0;
	logic                        quiet = 1'b0;
	int                          pairs_queued = 0;
	int                          pairs_taken = 0;
	int                          gap_left = 0;
	int                          stall_left = 0;
	int                          hold_left = 0;
	logic                        hold_done = 1'b0;
	int                          errors = 0;
	int                          cycles = 0;

	function automatic logic [ccs_pkg::ACC_W-1:0] add_clamped(
			input logic [ccs_pkg::ACC_W-1:0] acc,
			input logic [2*ccs_pkg::FIELD_W-1:0] v);
		logic [ccs_pkg::ACC_W:0] s;
		s = {1'b0, acc} + (ccs_pkg::ACC_W + 1)'(v);
		if (s[ccs_pkg::ACC_W]) begin
			overflow_seen = 1'b1;
			return ccs_pkg::ACC_MAX;
		end
		return s[ccs_pkg::ACC_W-1:0];
	endfunction

	// Largest q up to 1.0 in Q1.16 with q^2 * aa * bb <= 2^32 * ab^2.
	function automatic logic [ccs_pkg::SIM_W-1:0] ratio_q16(
			input logic [ccs_pkg::ACC_W-1:0] aa,
			input logic [ccs_pkg::ACC_W-1:0] bb, input logic [ccs_pkg::ACC_W-1:0] ab);
		logic [ccs_pkg::ROOT_W-1:0] den;
		logic [ccs_pkg::ROOT_W-1:0] num;
		logic [ccs_pkg::ROOT_W-1:0] lhs;
		logic [17:0]                lo;
		logic [17:0]                hi;
		logic [17:0]                mid;
		den = ccs_pkg::ROOT_W'(aa) * ccs_pkg::ROOT_W'(bb);
		num = (ccs_pkg::ROOT_W'(ab) * ccs_pkg::ROOT_W'(ab)) << 32;
		lo = '0;
		hi = 18'(ccs_pkg::ONE_Q16);
		while (lo < hi) begin
			mid = (lo + hi + 18'd1) >> 1;
			lhs = ccs_pkg::ROOT_W'(mid) * ccs_pkg::ROOT_W'(mid) * den;
			if (lhs <= num) begin
				lo = mid;
			end else begin
				hi = mid - 18'd1;
			end
		end
		return lo[ccs_pkg::SIM_W-1:0];
	endfunction

	function automatic void accumulate_pair(input pair_t p);
		logic [ccs_pkg::FIELD_W-1:0] a;
		logic [ccs_pkg::FIELD_W-1:0] b;
		similarity_t                 r;
		a = (p.count_a > clip_setting) ? '0 : p.count_a;
		b = (p.count_b > clip_setting) ? '0 : p.count_b;
		sum_aa = add_clamped(sum_aa, 32'(a) * 32'(a));
		sum_bb = add_clamped(sum_bb, 32'(b) * 32'(b));
		sum_ab = add_clamped(sum_ab, 32'(a) * 32'(b));
		if (p.last_element) begin
			r.zero_norm = (sum_aa == '0) || (sum_bb == '0);
			r.similarity = r.zero_norm ? '0 : ratio_q16(sum_aa, sum_bb, sum_ab);
			r.saturated = overflow_seen;
			similarity_due.insert(similarity_due.size(), r);
			sum_aa = '0;
			sum_bb = '0;
			sum_ab = '0;
			overflow_seen = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready) begin
				accumulate_pair(drive_pair);
				pairs_taken <= pairs_taken + 1;
			end
			if (!samples_if.valid || samples_if.ready) begin
				if (gap_left != 0) begin
					gap_left = gap_left - 1;
					samples_if.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(0, 9);
					samples_if.valid <= 1'b0;
				end else if (pairs_pending.size() != 0) begin
					drive_pair = pairs_pending.pop_front();
					samples_if.count_a <= drive_pair.count_a;
					samples_if.count_b <= drive_pair.count_b;
					samples_if.last_element <= drive_pair.last_element;
					samples_if.valid <= 1'b1;
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!hold_done && pairs_taken >= 150) begin
			hold_left <= 300;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		similarity_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				if (similarity_due.size() == 0) begin
					$error("result transfer with no result expected");
					errors = errors + 1;
				end else begin
					want = similarity_due.pop_front();
					if (result_if.similarity !== want.similarity) begin
						$error("similarity: expected %0d, got %0d", want.similarity,
							result_if.similarity);
						errors = errors + 1;
					end
					if (result_if.zero_norm !== want.zero_norm) begin
						$error("zero_norm: expected %0b, got %0b", want.zero_norm,
							result_if.zero_norm);
						errors = errors + 1;
					end
					if (result_if.saturated !== want.saturated) begin
						$error("saturated: expected %0b, got %0b", want.saturated,
							result_if.saturated);
						errors = errors + 1;
					end
				end
			end
			if (hold_left != 0) begin
				result_if.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left = stall_left - 1;
				result_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("clipped_cosine_similarity_unit: mismatch");
			$finish;
		end
	end

	function automatic void enqueue_pair(input pair_t p);
		pairs_pending.insert(pairs_pending.size(), p);
		pairs_queued = pairs_queued + 1;
	endfunction

	task automatic push_pair(input int a, input int b, input bit last);
		pair_t p;
		p.count_a = ccs_pkg::FIELD_W'(a);
		p.count_b = ccs_pkg::FIELD_W'(b);
		p.last_element = last;
		enqueue_pair(p);
	endtask

	task automatic settle();
		while (pairs_taken != pairs_queued || similarity_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_clip(input logic [ccs_pkg::FIELD_W-1:0] v);
		settle();
		cfg_if.clip_limit <= v;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		clip_setting = v;
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [ccs_pkg::FIELD_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return clip_setting;
			3: return clip_setting + 1'b1;
			4, 5: return ccs_pkg::FIELD_W'($urandom_range(0, clip_setting));
			6: return ccs_pkg::FIELD_W'($urandom_range(0, 255));
			default: return ccs_pkg::FIELD_W'($urandom());
		endcase
	endfunction

	task automatic queue_random_vectors(input int n_pairs);
		int    made;
		int    len;
		int    mode;
		int    roll;
		pair_t p;
		made = 0;
		while (made < n_pairs) begin
			roll = $urandom_range(0, 19);
			if (roll < 16) begin
				len = $urandom_range(1, 8);
			end else if (roll < 19) begin
				len = $urandom_range(9, 32);
			end else begin
				len = $urandom_range(33, 64);
			end
			mode = $urandom_range(0, 4);
			for (int i = 0; i < len; i++) begin
				p.count_a = pick_count();
				case (mode)
					1: p.count_b = p.count_a;
					2: p.count_b = p.count_a + ccs_pkg::FIELD_W'($urandom_range(0, 15));
					3: begin
						p.count_b = pick_count();
						p.count_a = '0;
					end
					default: p.count_b = pick_count();
				endcase
				p.last_element = (i == len - 1);
				enqueue_pair(p);
			end
			made += len;
		end
	endtask

	initial begin
		logic [ccs_pkg::FIELD_W-1:0] clip_plan[7];
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.count_a = '0;
		samples_if.count_b = '0;
		samples_if.last_element = 1'b0;
		result_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.clip_limit = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		push_pair(0, 0, 1);
		push_pair(65535, 65535, 1);
		push_pair(65535, 0, 1);
		push_pair(0, 65535, 1);
		push_pair(1, 0, 0);
		push_pair(0, 1, 1);
		push_pair(3, 4, 0);
		push_pair(4, 3, 1);
		push_pair(65535, 1, 0);
		push_pair(1, 65535, 0);
		push_pair(21845, 43690, 0);
		push_pair(43690, 21845, 1);
		write_clip(16'd100);
		push_pair(100, 101, 0);
		push_pair(101, 100, 0);
		push_pair(100, 100, 1);
		push_pair(101, 7, 1);
		write_clip(16'd0);
		push_pair(0, 0, 0);
		push_pair(1, 1, 1);

		clip_plan = '{16'hFFFF, 16'd1, 16'd255, ccs_pkg::FIELD_W'($urandom()), 16'd0,
			16'hFFFE, ccs_pkg::FIELD_W'($urandom())};
		foreach (clip_plan[k]) begin
			write_clip(clip_plan[k]);
			queue_random_vectors(145);
		end

		// The final batch runs with no idling on either side.
		write_clip(16'hFFFF);
		quiet = 1'b1;
		queue_random_vectors(60);

		settle();
		if (errors == 0) begin
			$display("clipped_cosine_similarity_unit: match");
		end else begin
			$display("clipped_cosine_similarity_unit: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/ccs_pkg.sv
src/ccs_chan_if.sv
src/ccs_mul.sv
src/ccs_root.sv
src/clipped_cosine_similarity_unit.sv
tb/tb.sv
